@@ src/servo_angle_ramp_pwm_unit_macros.svh @@
// ------------------------------------------------------------------------
// Servo angle ramp PWM unit assertion macros
// Shared concurrent assertion forms for the port-level checker.
// ------------------------------------------------------------------------
`ifndef SERVO_ANGLE_RAMP_PWM_UNIT_MACROS_SVH
`define SERVO_ANGLE_RAMP_PWM_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SARP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define SARP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

@@ src/sarp_pkg.sv @@
// ------------------------------------------------------------------------
// Servo angle ramp PWM package
// Shared types and constants for the servo ramp front end, queue and
// pulse calculation back end.
// ------------------------------------------------------------------------
package sarp_pkg;

	// Angle limit in 1/16 degree (plus or minus 90 degrees).
	localparam int ANG_LIMIT_16 = 1440;
	// Offset that maps -90..+90 degrees onto 0..180.
	localparam int ANGLE_OFFSET = 90;
	// Full angle span in degrees; the pulse divisor.
	localparam int SPAN_DEG = 180;

	// Division by 180: q = (num * DIV_RECIP) >> DIV_SHIFT, low by at most one.
	localparam int DIV_SHIFT = 24;
	localparam logic [16:0] DIV_RECIP = 17'd93206;

	// Register reset values.
	localparam logic [9:0] MIN_PULSE_RST = 10'd50;
	localparam logic [9:0] MAX_PULSE_RST = 10'd250;

	// Register index codes (address bit 2).
	localparam logic REG_MIN_PULSE = 1'b0;
	localparam logic REG_MAX_PULSE = 1'b1;

	// Input kind codes carried on tuser.
	localparam logic REQ_DELTA = 1'b0;
	localparam logic REQ_TICK  = 1'b1;

	// Default depth of the step queue.
	localparam int QUEUE_DEPTH_DEF = 2;

	// One angle step handed from the front end to the back end.
	typedef struct packed {
		logic signed [7:0] angle;
		logic              last;
	} step_t;

	// Pulse range registers.
	typedef struct packed {
		logic [9:0] min_pulse;
		logic [9:0] max_pulse;
	} pulse_cfg_t;

endpackage

@@ src/sarp_front.sv @@
// ------------------------------------------------------------------------
// Servo ramp front end
// Accepts delta and tick items, keeps position and target, and pushes
// one step record into the queue for every tick that moves the angle.
// ------------------------------------------------------------------------
module sarp_front import sarp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [12:0] delta_angle,
	input  logic        queue_full,
	output logic        push,
	output step_t       push_data
);

	logic signed [7:0]  pos_q;
	logic signed [11:0] target_q;
	logic signed [11:0] pos16;
	logic signed [12:0] diff;
	logic signed [12:0] diff_new;
	logic signed [13:0] tgt_raw;
	logic signed [11:0] tgt_clamped;
	logic signed [7:0]  pos_new;
	logic               accept;
	logic               move;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;

	// Position and target arithmetic in 1/16 degree.
	always_comb begin
		pos16   = {pos_q, 4'b0000};
		diff    = {pos16[11], pos16} - {target_q[11], target_q};
		move    = (diff >= 13'sd16) || (diff <= -13'sd16);
		if (diff < 13'sd0) begin
			pos_new  = pos_q + 8'sd1;
			diff_new = diff + 13'sd16;
		end else begin
			pos_new  = pos_q - 8'sd1;
			diff_new = diff - 13'sd16;
		end
		tgt_raw = {{2{pos16[11]}}, pos16} - {delta_angle[12], delta_angle};
		if (tgt_raw < -14'(ANG_LIMIT_16)) begin
			tgt_clamped = -12'(ANG_LIMIT_16);
		end else if (tgt_raw > 14'(ANG_LIMIT_16)) begin
			tgt_clamped = 12'(ANG_LIMIT_16);
		end else begin
			tgt_clamped = tgt_raw[11:0];
		end
	end

	// A tick that moves the angle produces one step record.
	assign push            = accept && (req_type == REQ_TICK) && move;
	assign push_data.angle = pos_new;
	assign push_data.last  = (diff_new > -13'sd16) && (diff_new < 13'sd16);

	// State update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			target_q <= '0;
		end else if (accept) begin
			if (req_type == REQ_DELTA) begin
				target_q <= tgt_clamped;
			end else if (move) begin
				pos_q <= pos_new;
			end
		end
	end

endmodule

@@ src/sarp_fifo.sv @@
// ------------------------------------------------------------------------
// Servo ramp step queue
// Short first-in first-out queue of step records between the front end
// and the pulse back end.
// ------------------------------------------------------------------------
module sarp_fifo import sarp_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  step_t push_data,
	input  logic  pop,
	output step_t pop_data,
	output logic  not_empty,
	output logic  full
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	step_t         mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign not_empty = (count_q != '0);
	assign full      = (count_q == CW'(DEPTH));
	assign pop_data  = mem_q[rd_ptr_q];

	// Storage write.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ src/sarp_back.sv @@
// ------------------------------------------------------------------------
// Servo ramp pulse back end
// Three-stage pipeline that turns a step record into the pulse value
// (angle+90)*(max-min)/180+min and holds the result for the output.
// ------------------------------------------------------------------------
module sarp_back import sarp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  pulse_cfg_t  cfg,
	input  logic        queue_valid,
	input  step_t       queue_data,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [9:0]  pwm_value,
	output logic signed [7:0] angle_now,
	output logic        last
);

	logic               adv;
	logic signed [10:0] span;
	logic signed [8:0]  offs;
	logic signed [19:0] prod_span;
	logic [17:0]        base;
	logic signed [19:0] num_sum;

	logic               v_s1;
	logic [17:0]        num_s1;
	step_t              step_s1;

	logic               v_s2;
	logic [17:0]        num_s2;
	logic [34:0]        prod_s2;
	step_t              step_s2;

	logic [9:0]         q_est;
	logic [17:0]        rem;
	logic [9:0]         pwm_fix;

	logic               v_s3;
	logic [9:0]         pwm_s3;
	step_t              step_s3;

	// The whole pipeline moves unless a result waits at the output.
	assign adv = !v_s3 || out_ready;
	assign pop = adv && queue_valid;

	// Stage 1 operands: numerator of the pulse formula.
	always_comb begin
		span      = $signed({1'b0, cfg.max_pulse}) - $signed({1'b0, cfg.min_pulse});
		offs      = {queue_data.angle[7], queue_data.angle} + 9'(ANGLE_OFFSET);
		prod_span = $signed({1'b0, offs[7:0]}) * span;
		base      = 18'(cfg.min_pulse) * 18'(SPAN_DEG);
		num_sum   = $signed({2'b00, base}) + prod_span;
	end

	// Stage 3 operands: correct the reciprocal estimate by one compare.
	always_comb begin
		q_est   = prod_s2[DIV_SHIFT +: 10];
		rem     = num_s2 - 18'(q_est) * 18'(SPAN_DEG);
		pwm_fix = (rem >= 18'(SPAN_DEG)) ? q_est + 10'd1 : q_est;
	end

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= queue_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage payloads.
	always_ff @(posedge clk) begin
		if (adv) begin
			num_s1  <= num_sum[17:0];
			step_s1 <= queue_data;
			num_s2  <= num_s1;
			prod_s2 <= 35'(num_s1) * 35'(DIV_RECIP);
			step_s2 <= step_s1;
			pwm_s3  <= pwm_fix;
			step_s3 <= step_s2;
		end
	end

	assign out_valid = v_s3;
	assign pwm_value = pwm_s3;
	assign angle_now = step_s3.angle;
	assign last      = step_s3.last;

endmodule

@@ src/servo_angle_ramp_pwm_unit.sv @@
// ------------------------------------------------------------------------
// Servo angle ramp PWM unit
// Slew-limited servo positioner with a pulse width output per step.
// ------------------------------------------------------------------------
// The unit accepts one item per clock cycle while the step queue is not
// full. A delta item sets the target angle at once and gives no result; a
// tick moves the angle one degree toward the target and, when it moves,
// raises m_axis_tvalid for its result once its step has passed through the
// step queue and the pulse pipeline. The front end state update sets this
// rate; the pulse division runs in a three-stage pipeline behind a step
// queue of QUEUE_DEPTH entries, so input transfers continue while a result
// waits at the output until the queue fills.
// Registers: min_pulse at byte address 0, max_pulse at byte address 4.
module servo_angle_ramp_pwm_unit import sarp_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [12:0] delta_angle, [15:13] zero
	input  logic [0:0]  s_axis_tuser,  // [0] req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // [9:0] pwm_value, [17:10] angle_now, [23:18] zero
	output logic        m_axis_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	pulse_cfg_t        cfg_q;
	logic              push;
	step_t             push_data;
	logic              pop;
	step_t             pop_data;
	logic              queue_valid;
	logic              queue_full;
	logic [9:0]        pwm_value;
	logic signed [7:0] angle_now;
	logic              reg_sel;

	// Configuration registers.
	assign pready  = 1'b1;
	assign reg_sel = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_pulse <= MIN_PULSE_RST;
			cfg_q.max_pulse <= MAX_PULSE_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_sel)
				REG_MIN_PULSE: cfg_q.min_pulse <= pwdata[9:0];
				REG_MAX_PULSE: cfg_q.max_pulse <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_MIN_PULSE: prdata = {22'd0, cfg_q.min_pulse};
			REG_MAX_PULSE: prdata = {22'd0, cfg_q.max_pulse};
			default:       prdata = '0;
		endcase
	end

	// Front end: item intake and ramp state.
	sarp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.req_type    (s_axis_tuser[0]),
		.delta_angle (s_axis_tdata[12:0]),
		.queue_full  (queue_full),
		.push        (push),
		.push_data   (push_data)
	);

	// Step queue.
	sarp_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.not_empty (queue_valid),
		.full      (queue_full)
	);

	// Back end: pulse value pipeline and output register.
	sarp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.queue_valid (queue_valid),
		.queue_data  (pop_data),
		.pop         (pop),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.pwm_value   (pwm_value),
		.angle_now   (angle_now),
		.last        (m_axis_tlast)
	);

	assign m_axis_tdata = {6'd0, angle_now, pwm_value};

endmodule

@@ src/sarp_checker.sv @@
// ------------------------------------------------------------------------
// Servo angle ramp PWM unit checker
// Port-level assertions on the result stream, bound to the top level.
// ------------------------------------------------------------------------
`include "servo_angle_ramp_pwm_unit_macros.svh"

module sarp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic        m_axis_tlast
);

	logic signed [7:0] prev_angle_q;
	logic signed [7:0] out_angle;
	logic              out_xfer;

	assign out_angle = m_axis_tdata[17:10];
	assign out_xfer  = m_axis_tvalid && m_axis_tready;

	// Angle of the last result transfer; the ramp starts at zero degrees.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_angle_q <= '0;
		end else if (out_xfer) begin
			prev_angle_q <= out_angle;
		end
	end

	// A stalled result holds its value.
	`SARP_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

	// Every result is one degree away from the result before it.
	`SARP_ASSERT_NOW(a_one_degree, clk, arst_n, out_xfer, (out_angle == prev_angle_q + 8'sd1) || (out_angle == prev_angle_q - 8'sd1))

	// The reported angle stays within plus or minus 90 degrees and the pad is zero.
	`SARP_ASSERT_NOW(a_angle_range, clk, arst_n, m_axis_tvalid, (out_angle >= -8'sd90) && (out_angle <= 8'sd90) && (m_axis_tdata[23:18] == 6'd0))

endmodule

bind servo_angle_ramp_pwm_unit sarp_checker u_sarp_checker (.*);

@@ dv/tb_top.sv @@
// ------------------------------------------------------------------------
// Servo angle ramp PWM unit testbench
// Drives delta and tick transfers into the slave stream, predicts each
// angle step and its pulse value, and compares every master stream
// transfer against the oldest predicted step. Pulse range registers are
// rewritten over the APB port between phases while the unit is idle.
// ------------------------------------------------------------------------
module tb_top;
	import sarp_pkg::*;

	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 160;
	localparam int DRAIN_CYCLES = 10;

	// One input item: its kind and the delta in 1/16 degree.
	typedef struct packed {
		logic              kind;
		logic signed [12:0] delta;
	} servo_item_t;

	// One predicted angle step.
	typedef struct packed {
		logic [9:0]        pwm;
		logic signed [7:0] angle;
		logic              last;
	} servo_step_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;   // [12:0] delta_angle, [15:13] zero
	logic [0:0]  s_axis_tuser = '0;   // [0] req_type
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;        // [9:0] pwm_value, [17:10] angle_now, [23:18] zero
	logic        m_axis_tlast;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// Items waiting to be offered and steps waiting to come out.
	servo_item_t item_queue[$];
	servo_step_t step_queue[$];

	// Predictor state: angle in degrees, target in 1/16 degree, pulse range.
	int angle_deg;
	int target_16;
	int pulse_min = MIN_PULSE_RST;
	int pulse_max = MAX_PULSE_RST;

	int n_pushed = 0;
	int n_accepted = 0;
	int n_errors = 0;
	int cycle_count = 0;
	int src_gap_max = 0;
	int snk_gap_max = 0;
	int src_gap_left = 0;
	int snk_stall_left = 0;
	int hold_left = 0;
	logic hold_arm = 1'b0;
	logic src_busy;
	servo_item_t cur_item = '0;
	servo_step_t oldest_step;

	servo_angle_ramp_pwm_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #6 clk = ~clk;

	// Mismatches are printed on one line each and counted.
	task automatic report(input string msg);
		$display("ERROR cycle %0d: %s", cycle_count, msg);
		n_errors++;
	endtask

	// Advance the angle model by one accepted item and queue any step.
	function automatic void servo_advance(input servo_item_t it);
		int t16;
		int diff;
		int num;
		servo_step_t s;
		if (it.kind == REQ_DELTA) begin
			t16 = angle_deg * 16 - int'(it.delta);
			if (t16 < -ANG_LIMIT_16) t16 = -ANG_LIMIT_16;
			if (t16 > ANG_LIMIT_16) t16 = ANG_LIMIT_16;
			target_16 = t16;
			return;
		end
		diff = angle_deg * 16 - target_16;
		if (diff < 16 && diff > -16) return;
		angle_deg += (diff < 0) ? 1 : -1;
		diff = angle_deg * 16 - target_16;
		num = SPAN_DEG * pulse_min + (angle_deg + ANGLE_OFFSET) * (pulse_max - pulse_min);
		if (num < 0) num = 0;
		s.pwm = 10'(num / SPAN_DEG);
		s.angle = 8'(angle_deg);
		s.last = (diff < 16 && diff > -16);
		step_queue.push_back(s);
	endfunction

	function automatic void push_item(input logic kind, input logic [12:0] delta);
		servo_item_t it;
		it.kind = kind;
		it.delta = delta;
		item_queue.push_back(it);
		n_pushed++;
	endfunction

	// Random phase: mostly a delta followed by a run of ticks, some noise.
	task automatic fill_random(input int n_items);
		int sel;
		int n_ticks;
		logic [12:0] d;
		while (item_queue.size() < n_items) begin
			sel = $urandom_range(0, 9);
			if (sel == 0) begin
				push_item(1'($urandom_range(0, 1)), 13'($urandom));
			end else begin
				if (sel < 5) d = 13'($urandom);
				else d = 13'(int'($urandom_range(0, 800)) - 400);
				push_item(REQ_DELTA, d);
				n_ticks = (sel == 9) ? $urandom_range(100, 190) : $urandom_range(1, 30);
				repeat (n_ticks) push_item(REQ_TICK, 13'($urandom));
			end
		end
	endtask

	// Register write: setup cycle, then access cycle.
	task automatic reg_write(input logic idx, input int value);
		logic [31:0] w;
		w = $urandom;
		w[9:0] = 10'(value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= w;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_MIN_PULSE) pulse_min = int'(w[9:0]);
		else pulse_max = int'(w[9:0]);
	endtask

	// Wait until every item is taken and every step has come out.
	task automatic wait_idle();
		while (n_accepted != n_pushed || step_queue.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Source side: offers queued items with random gaps between them.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			src_busy = s_axis_tvalid;
			if (s_axis_tvalid && s_axis_tready) begin
				servo_advance(cur_item);
				n_accepted++;
				src_busy = 1'b0;
			end
			if (!src_busy) begin
				if (src_gap_left > 0) begin
					src_gap_left--;
				end else if (item_queue.size() != 0) begin
					cur_item = item_queue.pop_front();
					src_gap_left = $urandom_range(0, src_gap_max);
					src_busy = 1'b1;
				end
			end
			s_axis_tvalid <= src_busy;
			s_axis_tdata <= {3'b000, cur_item.delta};
			s_axis_tuser <= cur_item.kind;
		end
	end

	// Long hold-off of the result side, counted on its own.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (hold_arm) begin
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Result side: checks each transfer against the oldest predicted step.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (step_queue.size() == 0) begin
					report($sformatf("result with no step expected, data %h", m_axis_tdata));
				end else begin
					oldest_step = step_queue.pop_front();
					if (m_axis_tdata[9:0] !== oldest_step.pwm)
						report($sformatf("pwm_value %0d, expected %0d",
							m_axis_tdata[9:0], oldest_step.pwm));
					if (m_axis_tdata[17:10] !== oldest_step.angle)
						report($sformatf("angle_now %0d, expected %0d",
							$signed(m_axis_tdata[17:10]), oldest_step.angle));
					if (m_axis_tlast !== oldest_step.last)
						report($sformatf("last %b, expected %b",
							m_axis_tlast, oldest_step.last));
				end
				snk_stall_left = $urandom_range(0, snk_gap_max);
			end else if (snk_stall_left != 0 && hold_left == 0) begin
				snk_stall_left--;
			end
			m_axis_tready <= (hold_left == 0) && (snk_stall_left == 0);
		end
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("servo_angle_ramp_pwm_unit: mismatch");
			$finish;
		end
	end

	// Stimulus: reset, directed items, then random phases with new ranges.
	initial begin
		int mins[8];
		int maxs[8];
		angle_deg = 0;
		target_16 = 0;
		mins = '{0, 1023, 0, 1023, -1, -1, 50, -1};
		maxs = '{1023, 0, 0, 1023, -1, -1, 250, -1};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset pulse range.
		push_item(REQ_TICK, 13'h0000);           // nothing to do yet
		push_item(REQ_DELTA, 13'h1FF1);          // target under one degree away
		push_item(REQ_TICK, 13'h1FFF);
		push_item(REQ_DELTA, 13'h1FF0);          // exactly one degree
		push_item(REQ_TICK, 13'h0AAA);
		push_item(REQ_TICK, 13'h1555);
		push_item(REQ_DELTA, 13'h1000);          // most negative delta, clamps high
		repeat (5) push_item(REQ_TICK, 13'($urandom));
		push_item(REQ_DELTA, 13'h0FFF);          // most positive, replaces the ramp
		repeat (3) push_item(REQ_TICK, 13'($urandom));
		push_item(REQ_DELTA, 13'h0000);          // target equals the angle
		push_item(REQ_TICK, 13'($urandom));
		push_item(REQ_DELTA, 13'h0001);          // one sixteenth off
		push_item(REQ_TICK, 13'($urandom));
		push_item(REQ_DELTA, 13'h1FEF);          // just over a degree
		push_item(REQ_TICK, 13'($urandom));
		push_item(REQ_TICK, 13'($urandom));
		wait_idle();

		// Random phases, each with its own pulse range and idling.
		for (int p = 0; p < 8; p++) begin
			reg_write(REG_MIN_PULSE, (mins[p] < 0) ? $urandom_range(0, 1023) : mins[p]);
			reg_write(REG_MAX_PULSE, (maxs[p] < 0) ? $urandom_range(0, 1023) : maxs[p]);
			src_gap_max = (p % 3 == 1) ? 0 : 5;
			snk_gap_max = (p % 3 == 2) ? 0 : 5;
			if (p == 2) begin
				hold_arm <= 1'b1;
				@(posedge clk);
				hold_arm <= 1'b0;
			end
			fill_random(PHASE_ITEMS);
			wait_idle();
		end

		if (n_errors == 0) begin
			$display("servo_angle_ramp_pwm_unit: match");
		end else begin
			$display("servo_angle_ramp_pwm_unit: mismatch");
		end
		$finish;
	end

endmodule
